// ----- sv/lacm_pkg.sv -----
// Shared widths and the queued item type of the look-at camera matrix block.
// Used by the front end, the item queue, the back end and the normalizer.
package lacm_pkg;

  localparam int unsigned CW    = 32;
  localparam int unsigned DW    = 33;
  localparam int unsigned NV_W  = 50;
  localparam int unsigned UV_W  = 18;
  localparam int unsigned WV_W  = 19;
  localparam int unsigned PW    = 52;
  localparam int unsigned CAM_W = 4;

  typedef struct packed {
    logic [2:0][DW-1:0] d;
    logic [2:0][DW-1:0] ne;
    logic [2:0][CW-1:0] up;
    logic [CAM_W-1:0]   cam;
  } item_t;

endpackage

// ----- sv/lacm_in_if.sv -----
// Input channel of the look-at camera matrix block: eye, target and up and camera index.
// Depends on nothing.
interface lacm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;
  logic [3:0]         cam_id;

  modport source(output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                 up_x, up_y, up_z, cam_id, input ready);
  modport sink(input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z, cam_id, output ready);
endinterface

// ----- sv/lacm_out_if.sv -----
// Output channel of the look-at camera matrix block: one matrix row per beat.
// Depends on nothing.
interface lacm_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         camera_slot;
  logic [1:0]         matrix_kind;
  logic [1:0]         row_number;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  logic               last_row;

  modport source(output valid, camera_slot, matrix_kind, row_number, col0, col1, col2,
                 col3, last_row, input ready);
  modport sink(input valid, camera_slot, matrix_kind, row_number, col0, col1, col2,
               col3, last_row, output ready);
endinterface

// ----- sv/lacm_front.sv -----
// Front end: accepts input beats, drops degenerate requests and forms queue items.
// Depends on lacm_pkg and lacm_in_if.
module lacm_front import lacm_pkg::*; #(
  parameter int unsigned CAMERAS = 16
) (
  lacm_in_if.sink in_i,
  input  logic    full_i,
  output logic    push_o,
  output item_t   item_o
);

  logic cam_ok;
  logic eye_zero;
  logic eye_on_tgt;

  assign cam_ok     = 32'(in_i.cam_id) < CAMERAS;
  assign eye_zero   = (in_i.eye_x == '0) && (in_i.eye_y == '0) && (in_i.eye_z == '0);
  assign eye_on_tgt = (in_i.eye_x == in_i.target_x) && (in_i.eye_y == in_i.target_y) &&
                      (in_i.eye_z == in_i.target_z);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && cam_ok && !eye_zero && !eye_on_tgt;

  always_comb begin
    item_o.d[0]  = DW'(in_i.target_x) - DW'(in_i.eye_x);
    item_o.d[1]  = DW'(in_i.target_y) - DW'(in_i.eye_y);
    item_o.d[2]  = DW'(in_i.target_z) - DW'(in_i.eye_z);
    item_o.ne[0] = -DW'(in_i.eye_x);
    item_o.ne[1] = -DW'(in_i.eye_y);
    item_o.ne[2] = -DW'(in_i.eye_z);
    item_o.up[0] = in_i.up_x;
    item_o.up[1] = in_i.up_y;
    item_o.up[2] = in_i.up_z;
    item_o.cam   = in_i.cam_id;
  end

endmodule

// ----- sv/lacm_queue.sv -----
// Two-entry item queue between the front end and the back end.
// Depends on lacm_pkg.
module lacm_queue import lacm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      slot_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("queue count slip");

endmodule

// ----- sv/lacm_norm.sv -----
// Vector normalizer: range scaling, sum of squares, bit-serial square root and
// three parallel restoring dividers. Depends on lacm_pkg.
module lacm_norm import lacm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NV_W-1:0] vec_i [3],
  output logic                   done_o,
  output logic signed [UV_W-1:0] res_o [3]
);

  localparam int unsigned SC_W  = 30;
  localparam int unsigned SUM_W = 62;
  localparam int unsigned RT_W  = 64;
  localparam int unsigned LEN_W = 31;
  localparam int unsigned QW    = 17;
  localparam int unsigned NUM_W = SC_W + 16 + 1;

  typedef enum logic [4:0] {
    N_IDLE  = 5'b00001,
    N_SCALE = 5'b00010,
    N_SQ    = 5'b00100,
    N_ROOT  = 5'b01000,
    N_DIV   = 5'b10000
  } nst_e;

  nst_e                   st_q, st_d;
  logic                   done_q, done_d;
  logic [NV_W-1:0]        mag_q [3];
  logic [2:0]             neg_q;
  logic [NV_W-1:0]        orv;
  logic [2*SC_W-1:0]      prod_q;
  logic [SUM_W-1:0]       sum_q;
  logic [1:0]             cnt_q;
  logic [RT_W-1:0]        rn_q, res_q, bit_q, trial, res_nx;
  logic                   ge;
  logic [LEN_W-1:0]       len;
  logic [NUM_W-1:0]       num [3];
  logic [31:0]            rem_q [3];
  logic [31:0]            sh [3];
  logic [QW-1:0]          lo_q [3];
  logic [QW-1:0]          quo_q [3];
  logic [QW-1:0]          quo_nx [3];
  logic [2:0]             qb;
  logic [4:0]             dcnt_q;
  logic signed [UV_W-1:0] out_q [3];

  assign orv    = mag_q[0] | mag_q[1] | mag_q[2];
  assign trial  = res_q + bit_q;
  assign ge     = rn_q >= trial;
  assign res_nx = ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
  assign len    = (st_q == N_ROOT) ? res_nx[LEN_W-1:0] : res_q[LEN_W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k]    = {1'b0, mag_q[k][SC_W-1:0], 16'b0} + NUM_W'(len >> 1);
      sh[k]     = {rem_q[k][30:0], lo_q[k][QW-1]};
      qb[k]     = sh[k] >= 32'(len);
      quo_nx[k] = {quo_q[k][QW-2:0], qb[k]};
    end
  end

  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    case (st_q)
      N_IDLE: begin
        if (start_i) st_d = N_SCALE;
      end
      N_SCALE: begin
        if (orv == '0) begin
          st_d   = N_IDLE;
          done_d = 1'b1;
        end else if (orv[SC_W-1] && (orv[NV_W-1:SC_W] == '0)) begin
          st_d = N_SQ;
        end
      end
      N_SQ: begin
        if (cnt_q == 2'd3) st_d = N_ROOT;
      end
      N_ROOT: begin
        if (bit_q[0]) st_d = N_DIV;
      end
      N_DIV: begin
        if (dcnt_q == 5'(QW - 1)) begin
          st_d   = N_IDLE;
          done_d = 1'b1;
        end
      end
      default: st_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      N_IDLE: begin
        if (start_i) begin
          for (int k = 0; k < 3; k++) begin
            mag_q[k] <= vec_i[k][NV_W-1] ? NV_W'(-vec_i[k]) : NV_W'(vec_i[k]);
            neg_q[k] <= vec_i[k][NV_W-1];
          end
        end
      end
      N_SCALE: begin
        if (orv == '0) begin
          for (int k = 0; k < 3; k++) out_q[k] <= '0;
        end else if (orv[NV_W-1:SC_W+8] != '0) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 8;
        end else if (orv[NV_W-1:SC_W] != '0) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
        end else if (orv[SC_W-1:SC_W-9] == '0) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 8;
        end else if (!orv[SC_W-1]) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
        end else begin
          cnt_q <= 2'd0;
          sum_q <= '0;
        end
      end
      N_SQ: begin
        if (cnt_q != 2'd3) begin
          prod_q <= mag_q[cnt_q][SC_W-1:0] * mag_q[cnt_q][SC_W-1:0];
        end
        if (cnt_q != 2'd0) sum_q <= sum_q + SUM_W'(prod_q);
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          rn_q  <= RT_W'(sum_q) + RT_W'(prod_q);
          res_q <= '0;
          bit_q <= RT_W'(1) << 62;
        end
      end
      N_ROOT: begin
        if (ge) rn_q <= rn_q - trial;
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          for (int k = 0; k < 3; k++) begin
            rem_q[k] <= 32'(num[k][NUM_W-1:QW]);
            lo_q[k]  <= num[k][QW-1:0];
            quo_q[k] <= '0;
          end
          dcnt_q <= '0;
        end
      end
      N_DIV: begin
        for (int k = 0; k < 3; k++) begin
          rem_q[k] <= qb[k] ? (sh[k] - 32'(len)) : sh[k];
          lo_q[k]  <= lo_q[k] << 1;
          quo_q[k] <= quo_nx[k];
          if (dcnt_q == 5'(QW - 1)) begin
            out_q[k] <= neg_q[k] ? -$signed({1'b0, quo_nx[k]}) : $signed({1'b0, quo_nx[k]});
          end
        end
        dcnt_q <= dcnt_q + 5'd1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = out_q;

endmodule

// ----- sv/lacm_back.sv -----
// Back end: sequences the normalizer and a shared multiply-accumulate unit, then
// emits the twelve matrix rows through an output register. Depends on lacm_pkg,
// lacm_out_if and lacm_norm.
module lacm_back import lacm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  lacm_out_if.source out_o
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_NORM_D  = 9'b000000010,
    ST_CROSS   = 9'b000000100,
    ST_DRAIN_X = 9'b000001000,
    ST_NORM_T  = 9'b000010000,
    ST_NORM_U  = 9'b000100000,
    ST_MACS    = 9'b001000000,
    ST_DRAIN_M = 9'b010000000,
    ST_EMIT    = 9'b100000000
  } st_e;

  typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_SUB} op_e;
  typedef enum logic [2:0] {DK_NONE, DK_T, DK_AY, DK_BW, DK_TR} dk_e;
  typedef enum logic [1:0] {MK_VIEW, MK_BILL, MK_YBB} mk_e;

  localparam logic [4:0] STEP_X_END = 5'd5;
  localparam logic [4:0] STEP_M_BEG = 5'd6;
  localparam logic [4:0] STEP_AY    = 5'd12;
  localparam logic [4:0] STEP_DOT   = 5'd18;
  localparam logic [4:0] STEP_M_END = 5'd26;
  localparam logic signed [PW-1:0] SAT_HI  = PW'(64'h7FFF_FFFF);
  localparam logic signed [PW-1:0] SAT_LO  = ~SAT_HI;
  localparam logic signed [CW-1:0] ONE_Q16 = 32'sd65536;

  function automatic logic signed [PW-1:0] rnd16(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    r   = (mag + PW'(32768)) >> 16;
    return v[PW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [CW-1:0] sat32(input logic signed [PW-1:0] v);
    if (v > SAT_HI) return SAT_HI[CW-1:0];
    if (v < SAT_LO) return SAT_LO[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic [1:0] nxt(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  st_e                    state_q, state_d;
  logic                   first_q, first_d;
  logic [4:0]             s_q, s_d;
  mk_e                    kind_q, kind_d;
  logic [1:0]             row_q, row_d;
  logic                   out_valid_q;
  logic                   out_load;

  item_t                  item_q;
  logic signed [UV_W-1:0] az_q [3];
  logic signed [UV_W-1:0] ax_q [3];
  logic signed [UV_W-1:0] bu_q [3];
  logic signed [WV_W-1:0] ay_q [3];
  logic signed [WV_W-1:0] bw_q [3];
  logic signed [NV_W-1:0] t_q [3];
  logic signed [CW-1:0]   tr_q [3];

  logic                   issue_v;
  logic signed [DW-1:0]   a_v;
  logic signed [WV_W-1:0] b_v;
  op_e                    op_v, op_q;
  dk_e                    dk_v, dk_q;
  logic [1:0]             ix_v, ix_q;
  logic                   v2_q;
  logic signed [PW-1:0]   p_q, acc_q, acc_d, rnd_w;

  logic                   n_start, n_done;
  logic signed [NV_W-1:0] n_vec [3];
  logic signed [UV_W-1:0] n_res [3];

  logic [1:0]             j_k, ia, ib, dc, dv;
  logic                   j_sec;
  logic [4:0]             j;
  logic signed [CW-1:0]   c_d [4];

  lacm_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (n_start),
    .vec_i   (n_vec),
    .done_o  (n_done),
    .res_o   (n_res)
  );

  assign n_start = first_q &&
                   (state_q == ST_NORM_D || state_q == ST_NORM_T || state_q == ST_NORM_U);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (state_q)
        ST_NORM_T: n_vec[k] = t_q[k];
        ST_NORM_U: n_vec[k] = NV_W'($signed(item_q.up[k]));
        default:   n_vec[k] = NV_W'($signed(item_q.d[k]));
      endcase
    end
  end

  assign issue_v = (state_q == ST_CROSS) || (state_q == ST_MACS);

  always_comb begin
    a_v   = '0;
    b_v   = '0;
    op_v  = OP_LOAD;
    dk_v  = DK_NONE;
    ix_v  = 2'd0;
    dc    = 2'd0;
    dv    = 2'd0;
    j     = s_q;
    if (s_q >= STEP_DOT) begin
      j = s_q - STEP_DOT;
    end else if (s_q >= STEP_AY) begin
      j = s_q - STEP_AY;
    end else if (s_q >= STEP_M_BEG) begin
      j = s_q - STEP_M_BEG;
    end
    j_k   = j[2:1];
    j_sec = j[0];
    ia    = j_sec ? nxt(nxt(j_k)) : nxt(j_k);
    ib    = j_sec ? nxt(j_k) : nxt(nxt(j_k));
    if (s_q < STEP_DOT) begin
      op_v = j_sec ? OP_SUB : OP_LOAD;
      ix_v = j_k;
      if (s_q < STEP_M_BEG) begin
        a_v = DW'($signed(item_q.up[ia]));
        b_v = WV_W'(az_q[ib]);
        if (j_sec) dk_v = DK_T;
      end else if (s_q < STEP_AY) begin
        a_v = DW'(az_q[ia]);
        b_v = WV_W'(ax_q[ib]);
        if (j_sec) dk_v = DK_AY;
      end else begin
        a_v = DW'(ax_q[ia]);
        b_v = WV_W'(bu_q[ib]);
        if (j_sec) dk_v = DK_BW;
      end
    end else begin
      case (j)
        5'd0:    begin dv = 2'd0; dc = 2'd0; end
        5'd1:    begin dv = 2'd0; dc = 2'd1; end
        5'd2:    begin dv = 2'd0; dc = 2'd2; end
        5'd3:    begin dv = 2'd1; dc = 2'd0; end
        5'd4:    begin dv = 2'd1; dc = 2'd1; end
        5'd5:    begin dv = 2'd1; dc = 2'd2; end
        5'd6:    begin dv = 2'd2; dc = 2'd0; end
        5'd7:    begin dv = 2'd2; dc = 2'd1; end
        default: begin dv = 2'd2; dc = 2'd2; end
      endcase
      a_v  = $signed(item_q.ne[dc]);
      case (dv)
        2'd0:    b_v = WV_W'(ax_q[dc]);
        2'd1:    b_v = ay_q[dc];
        default: b_v = WV_W'(az_q[dc]);
      endcase
      op_v = (dc == 2'd0) ? OP_LOAD : OP_ADD;
      ix_v = dv;
      if (dc == 2'd2) dk_v = DK_TR;
    end
  end

  always_comb begin
    case (op_q)
      OP_ADD:  acc_d = acc_q + p_q;
      OP_SUB:  acc_d = acc_q - p_q;
      default: acc_d = p_q;
    endcase
    rnd_w = rnd16(acc_d);
  end

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    first_d = 1'b0;
    s_d     = s_q;
    kind_d  = kind_q;
    row_d   = row_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_NORM_D;
          first_d = 1'b1;
        end
      end
      ST_NORM_D: begin
        if (n_done) begin
          state_d = ST_CROSS;
          s_d     = '0;
        end
      end
      ST_CROSS: begin
        s_d = s_q + 5'd1;
        if (s_q == STEP_X_END) state_d = ST_DRAIN_X;
      end
      ST_DRAIN_X: begin
        state_d = ST_NORM_T;
        first_d = 1'b1;
      end
      ST_NORM_T: begin
        if (n_done) begin
          state_d = ST_NORM_U;
          first_d = 1'b1;
        end
      end
      ST_NORM_U: begin
        if (n_done) begin
          state_d = ST_MACS;
          s_d     = STEP_M_BEG;
        end
      end
      ST_MACS: begin
        s_d = s_q + 5'd1;
        if (s_q == STEP_M_END) state_d = ST_DRAIN_M;
      end
      ST_DRAIN_M: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          row_d = row_q + 2'd1;
          if (row_q == 2'd3) begin
            case (kind_q)
              MK_VIEW: kind_d = MK_BILL;
              MK_BILL: kind_d = MK_YBB;
              default: begin
                kind_d  = MK_VIEW;
                state_d = ST_IDLE;
              end
            endcase
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) c_d[k] = '0;
    if (row_q == 2'd3) begin
      c_d[3] = ONE_Q16;
      if (kind_q == MK_VIEW) begin
        for (int k = 0; k < 3; k++) c_d[k] = tr_q[k];
      end
    end else if (kind_q == MK_VIEW) begin
      c_d[0] = CW'(ax_q[row_q]);
      c_d[1] = CW'(ay_q[row_q]);
      c_d[2] = CW'(az_q[row_q]);
    end else begin
      for (int k = 0; k < 3; k++) begin
        case (row_q)
          2'd0:    c_d[k] = CW'(ax_q[k]);
          2'd1:    c_d[k] = (kind_q == MK_BILL) ? CW'(ay_q[k]) : CW'(bu_q[k]);
          default: c_d[k] = (kind_q == MK_BILL) ? CW'(az_q[k]) : CW'(bw_q[k]);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b0;
      s_q         <= '0;
      kind_q      <= MK_VIEW;
      row_q       <= '0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      s_q     <= s_d;
      kind_q  <= kind_d;
      row_q   <= row_d;
      v2_q    <= issue_v;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_item_i;
    if (n_done) begin
      case (state_q)
        ST_NORM_D: az_q <= n_res;
        ST_NORM_T: ax_q <= n_res;
        default:   bu_q <= n_res;
      endcase
    end
    p_q  <= PW'(a_v) * PW'(b_v);
    op_q <= op_v;
    dk_q <= dk_v;
    ix_q <= ix_v;
    if (v2_q) begin
      acc_q <= acc_d;
      case (dk_q)
        DK_T:    t_q[ix_q]  <= acc_d[NV_W-1:0];
        DK_AY:   ay_q[ix_q] <= rnd_w[WV_W-1:0];
        DK_BW:   bw_q[ix_q] <= rnd_w[WV_W-1:0];
        DK_TR:   tr_q[ix_q] <= sat32(rnd_w);
        default: ;
      endcase
    end
    if (out_load) begin
      out_o.camera_slot <= item_q.cam;
      out_o.matrix_kind <= kind_q;
      out_o.row_number  <= row_q;
      out_o.col0        <= c_d[0];
      out_o.col1        <= c_d[1];
      out_o.col2        <= c_d[2];
      out_o.col3        <= c_d[3];
      out_o.last_row    <= (kind_q == MK_YBB) && (row_q == 2'd3);
    end
  end

  assign out_o.valid = out_valid_q;

  a_done_in_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_done |-> (state_q == ST_NORM_D || state_q == ST_NORM_T || state_q == ST_NORM_U))
    else $error("normalizer finished outside a normalize phase");
  a_mac_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !v2_q)
    else $error("multiply-accumulate still busy during row output");
  a_rows_rewound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (kind_q == MK_VIEW && row_q == 2'd0))
    else $error("row counters not rewound between items");

endmodule

// ----- sv/look_at_camera_matrices.sv -----
// Look-at camera matrices, left-handed, signed Q16.16.
// Input channel in_i: one beat carries eye, target and up vectors and a camera
// index. Degenerate requests (eye at the origin, eye on the target, index not
// below CAMERAS) are taken and produce no rows.
// Output channel out_o: each kept request yields twelve beats, the four rows of
// the view matrix, then the full billboard matrix, then the Y-axis billboard
// matrix; last_row marks the twelfth beat.
// The front end takes a beat whenever the two-entry queue has room, so up to two
// requests wait while one is computed. After an item leaves the queue, the back
// end runs three normalizations, each bound by the one-bit-per-cycle square root
// and the restoring dividers (a zero vector skips both and yields zero), and then
// the shared multiply-accumulate unit. Rows then leave one per cycle while the
// receiver is ready. The back end takes the next request from the queue only
// after the last row of the current one is in the output register.
// A stalled receiver holds the current row in the output register and halts the
// back end; the queue keeps filling until full. Reset empties the queue and
// returns the sequencer to idle; no result beat is pending after reset.
// Depends on lacm_pkg, lacm_in_if, lacm_out_if, lacm_front, lacm_queue, lacm_back.
module look_at_camera_matrices import lacm_pkg::*; #(
  parameter int unsigned CAMERAS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lacm_in_if.sink    in_i,
  lacm_out_if.source out_o
);

  logic  push;
  logic  full;
  logic  pop;
  logic  q_valid;
  item_t push_item;
  item_t q_item;

  lacm_front #(.CAMERAS(CAMERAS)) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  lacm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  lacm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule
